FILE: sv/vsl_pkg.sv
// Shared types, constants and saturation helper for the vsync listener scheduler.
// No dependencies; used by vsync_listener_scheduler_core.
package vsl_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = $clog2(SLOTS);

	localparam logic [2:0] ACT_SCHED  = 3'd0;
	localparam logic [2:0] ACT_FIRE   = 3'd1;
	localparam logic [2:0] ACT_ADD    = 3'd2;
	localparam logic [2:0] ACT_REMOVE = 3'd3;
	localparam logic [2:0] ACT_PHASE  = 3'd4;

	localparam logic [1:0] REG_PERIOD = 2'd0;
	localparam logic [1:0] REG_GPHASE = 2'd1;
	localparam logic [1:0] REG_REFT   = 2'd2;
	localparam logic [1:0] REG_LTPS   = 2'd3;

	localparam logic [29:0] PERIOD_RST = 30'd16666667;
	localparam logic signed [64:0] DUE_WIN   = 65'sd500000;
	localparam logic signed [65:0] DELAY_MAX = 66'sd1500000;
	localparam logic signed [65:0] DELAY_MIN = -66'sd2147483648;
	localparam logic signed [64:0] T_MAX = 65'sh0_3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [64:0] T_MIN = -T_MAX - 65'sd1;
	localparam logic [63:0] RECIP5 = 64'h0000_0000_CCCC_CCCD;

	typedef struct packed {
		logic signed [30:0] phase;
		logic signed [62:0] last;
	} ent_t;

	function automatic logic signed [62:0] c63(input logic signed [64:0] x);
		logic signed [64:0] y;
		y = x;
		if (x > T_MAX) y = T_MAX;
		if (x < T_MIN) y = T_MIN;
		return y[62:0];
	endfunction

	function automatic logic signed [64:0] x63(input logic signed [62:0] v);
		return $signed({{2{v[62]}}, v});
	endfunction

endpackage

FILE: sv/vsync_listener_scheduler_core.sv
// Vsync listener scheduler: slot table in a synchronous memory, iterative remainder unit.
// Depends on vsl_pkg.
//
// Usage:
//  s_axis carries one item: tuser = action, tdata = listener_id, phase_offset,
//  now_time, target_time, woke_on_timeout. m_axis returns the result items, tlast
//  marking the final one of an item. cfg writes period, global_phase, reference_time and
//  ltps_mode by index; the user must write only while idle; not enforced by the block.
//  Schedule and fire walk all slots; each valid slot goes through read and load steps,
//  the one-bit-per-cycle remainder unit (62 steps) and finish steps.
//  Fire adds a push step for every due slot after the first. An empty slot is
//  skipped after its read step. Add, remove and rephase run delay, op and finish steps.
//  One item is worked on at a time; s_axis_tready is high only when idle.
//  A result waits in the output register while m_axis_tready is low; the walk
//  holds at its next push or finish step until it is taken. Reset empties all slots,
//  zeroes the wakeup delay and restores register defaults; no clearing pass is needed.
module vsync_listener_scheduler_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// listener_id[3:0], phase_offset[34:4], now_time[96:35], target_time[158:97],
	// woke_on_timeout[159]
	input  logic [159:0] s_axis_tdata,
	// action[2:0]
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// slot[3:0], event_time[66:4], has_time[67], status[68], zero[71:69]
	output logic [71:0]  m_axis_tdata,
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [61:0]  cfg_data
);

	localparam logic [3:0] S_IDLE = 4'd0,  S_DLY = 4'd1,  S_OP = 4'd2,   S_RD = 4'd3,
	                       S_LD = 4'd4,    S_S2 = 4'd5,   S_S3 = 4'd6,   S_DIV = 4'd7,
	                       S_F1 = 4'd8,    S_F2 = 4'd9,   S_F3 = 4'd10,  S_F4 = 4'd11,
	                       S_EVAL = 4'd12, S_PUSH = 4'd13, S_NEXT = 4'd14, S_FIN = 4'd15;

	logic [3:0] st_q;
	logic [29:0] period_q;
	logic signed [30:0] gph_q;
	logic [61:0] ref_q;
	logic ltps_q;
	logic [vsl_pkg::SLOTS-1:0] valid_q;
	logic signed [31:0] delay_q;
	logic [31:0] trip_q;
	logic [29:0] tp_q;

	logic [2:0] act_q;
	logic [3:0] id_q;
	logic signed [30:0] phin_q;
	logic [61:0] now_q, tgt_q;
	logic woke_q;
	logic signed [62:0] nowsel_q;

	vsl_pkg::ent_t mem [vsl_pkg::SLOTS];
	vsl_pkg::ent_t rd_q;
	vsl_pkg::ent_t wd;
	logic we;
	logic [vsl_pkg::SLOT_W-1:0] wa;

	logic [vsl_pkg::SLOT_W-1:0] idx_q;
	logic signed [62:0] a_q, last_q, n_q, t_q, tpl_q, best_q, pend_t_q;
	logic signed [31:0] sph_q;
	logic signed [30:0] phs_q;
	logic neg_q, cond_q, any_q, pend_v_q, stat_q;
	logic [vsl_pkg::SLOT_W-1:0] pend_s_q;
	logic [29:0] rem_q;
	logic [61:0] dv_q;
	logic [5:0] cnt_q;

	logic ov_q, ol_q;
	logic [71:0] od_q;

	logic [29:0] pe;
	logic signed [64:0] pe65, now65, tgt65, ref65, dly65, dnt;
	logic signed [62:0] lastv, n2, addlast, tdiff;
	logic signed [65:0] dx, sum66, q66;
	logic [30:0] rem31;
	logic [63:0] prod;
	logic out_free, in_acc, inrange, due, emit;

	assign pe     = (period_q == 30'd0) ? 30'd1 : period_q;
	assign pe65   = $signed({35'd0, pe});
	assign now65  = $signed({3'd0, now_q});
	assign tgt65  = $signed({3'd0, tgt_q});
	assign ref65  = $signed({3'd0, ref_q});
	assign dly65  = $signed({{33{delay_q[31]}}, delay_q});
	assign lastv  = vsl_pkg::c63(vsl_pkg::x63(rd_q.last) + dly65);
	assign n2     = vsl_pkg::c63(vsl_pkg::x63(n_q) - $signed({{33{sph_q[31]}}, sph_q}));
	assign addlast = vsl_pkg::c63(now65 - $signed({36'd0, pe[29:1]})
		+ $signed({{34{gph_q[30]}}, gph_q}));
	assign tdiff  = vsl_pkg::c63(vsl_pkg::x63(t_q) - vsl_pkg::x63(last_q));
	assign due    = (vsl_pkg::x63(t_q) - now65) < vsl_pkg::DUE_WIN;
	assign rem31  = {rem_q, dv_q[61]};
	assign prod   = {32'd0, trip_q} * vsl_pkg::RECIP5;
	assign dx     = $signed({{34{delay_q[31]}}, delay_q});
	assign dnt    = now65 - tgt65;
	assign sum66  = (dx <<< 6) - dx + $signed({dnt[64], dnt});
	assign q66    = (sum66 < 0) ? ((sum66 + 66'sd63) >>> 6) : (sum66 >>> 6);
	assign inrange = {1'b0, id_q} < 5'(vsl_pkg::SLOTS);
	assign out_free = !ov_q || m_axis_tready;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign emit   = ((st_q == S_PUSH) || (st_q == S_FIN)) && out_free;

	assign s_axis_tready = (st_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = od_q;
	assign m_axis_tlast  = ol_q;

	always_comb begin
		we = 1'b0;
		wa = idx_q;
		wd = '{phase: phs_q, last: t_q};
		if (st_q == S_OP && act_q == vsl_pkg::ACT_ADD && inrange) begin
			we = 1'b1;
			wa = id_q[vsl_pkg::SLOT_W-1:0];
			wd = '{phase: phin_q, last: addlast};
		end else if (st_q == S_OP && act_q == vsl_pkg::ACT_PHASE && inrange
				&& valid_q[id_q[vsl_pkg::SLOT_W-1:0]]) begin
			we = 1'b1;
			wa = id_q[vsl_pkg::SLOT_W-1:0];
			wd = '{phase: phin_q, last: rd_q.last};
		end else if (st_q == S_EVAL && act_q == vsl_pkg::ACT_FIRE && due) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= vsl_pkg::PERIOD_RST;
			gph_q    <= '0;
			ref_q    <= '0;
			ltps_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				vsl_pkg::REG_PERIOD: period_q <= cfg_data[29:0];
				vsl_pkg::REG_GPHASE: gph_q    <= $signed(cfg_data[30:0]);
				vsl_pkg::REG_REFT:   ref_q    <= cfg_data;
				vsl_pkg::REG_LTPS:   ltps_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		trip_q <= {2'd0, pe} + {1'b0, pe, 1'b0};
		tp_q   <= prod[63:34];
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q  <= s_axis_tuser;
			id_q   <= s_axis_tdata[3:0];
			phin_q <= $signed(s_axis_tdata[34:4]);
			now_q  <= s_axis_tdata[96:35];
			tgt_q  <= s_axis_tdata[158:97];
			woke_q <= s_axis_tdata[159];
		end
		unique case (st_q)
			S_LD: begin
				a_q    <= (vsl_pkg::x63(nowsel_q) < vsl_pkg::x63(lastv)) ? lastv : nowsel_q;
				sph_q  <= {gph_q[30], gph_q} + {rd_q.phase[30], rd_q.phase};
				last_q <= rd_q.last;
				phs_q  <= rd_q.phase;
			end
			S_S2: n_q <= vsl_pkg::c63(vsl_pkg::x63(a_q) - ref65);
			S_S3: begin
				n_q   <= n2;
				neg_q <= n2[62];
				dv_q  <= n2[61:0];
				rem_q <= '0;
				cnt_q <= '0;
			end
			S_DIV: begin
				rem_q <= (rem31 >= {1'b0, pe}) ? 30'(rem31 - {1'b0, pe}) : rem31[29:0];
				dv_q  <= {dv_q[60:0], 1'b0};
				cnt_q <= cnt_q + 6'd1;
			end
			S_F1: t_q <= neg_q ? 63'(sph_q)
				: vsl_pkg::c63(vsl_pkg::x63(n_q) - $signed({35'd0, rem_q}) + pe65
					+ $signed({{33{sph_q[31]}}, sph_q}));
			S_F2: t_q <= vsl_pkg::c63(vsl_pkg::x63(t_q) + ref65);
			S_F3: begin
				cond_q <= ltps_q && (vsl_pkg::x63(tdiff) < $signed({35'd0, tp_q}));
				tpl_q  <= vsl_pkg::c63(vsl_pkg::x63(t_q) + pe65);
			end
			S_F4: t_q <= vsl_pkg::c63(vsl_pkg::x63(cond_q ? tpl_q : t_q) - dly65);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			valid_q  <= '0;
			delay_q  <= '0;
			idx_q    <= '0;
			nowsel_q <= '0;
			best_q   <= '0;
			any_q    <= 1'b0;
			pend_v_q <= 1'b0;
			pend_s_q <= '0;
			pend_t_q <= '0;
			stat_q   <= 1'b0;
			ov_q     <= 1'b0;
			ol_q     <= 1'b0;
			od_q     <= '0;
		end else begin
			if (m_axis_tready && !emit) ov_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (in_acc) begin
					idx_q    <= (s_axis_tuser == vsl_pkg::ACT_SCHED
						|| s_axis_tuser == vsl_pkg::ACT_FIRE) ? '0
						: s_axis_tdata[vsl_pkg::SLOT_W-1:0];
					any_q    <= 1'b0;
					best_q   <= '0;
					pend_v_q <= 1'b0;
					stat_q   <= 1'b0;
					nowsel_q <= $signed({1'b0, s_axis_tdata[96:35]});
					if (s_axis_tuser == vsl_pkg::ACT_SCHED) st_q <= S_RD;
					else st_q <= S_DLY;
				end
				S_DLY: begin
					if (act_q == vsl_pkg::ACT_FIRE) begin
						if (woke_q) begin
							if (q66 > vsl_pkg::DELAY_MAX)
								delay_q <= 32'(vsl_pkg::DELAY_MAX);
							else if (q66 < vsl_pkg::DELAY_MIN)
								delay_q <= 32'(vsl_pkg::DELAY_MIN);
							else delay_q <= q66[31:0];
						end
						if (ltps_q) nowsel_q <= 63'(now65 - pe65);
						st_q <= S_RD;
					end else begin
						st_q <= S_OP;
					end
				end
				S_OP: begin
					case (act_q) inside
						vsl_pkg::ACT_ADD: if (inrange)
							valid_q[id_q[vsl_pkg::SLOT_W-1:0]] <= 1'b1;
							else stat_q <= 1'b1;
						vsl_pkg::ACT_REMOVE, vsl_pkg::ACT_PHASE:
							if (!inrange || !valid_q[id_q[vsl_pkg::SLOT_W-1:0]])
								stat_q <= 1'b1;
							else if (act_q == vsl_pkg::ACT_REMOVE)
								valid_q[id_q[vsl_pkg::SLOT_W-1:0]] <= 1'b0;
						default: ;
					endcase
					st_q <= S_FIN;
				end
				S_RD:  st_q <= valid_q[idx_q] ? S_LD : S_NEXT;
				S_LD:  st_q <= S_S2;
				S_S2:  st_q <= S_S3;
				S_S3:  st_q <= S_DIV;
				S_DIV: if (cnt_q == 6'd61) st_q <= S_F1;
				S_F1:  st_q <= S_F2;
				S_F2:  st_q <= S_F3;
				S_F3:  st_q <= S_F4;
				S_F4:  st_q <= S_EVAL;
				S_EVAL: begin
					st_q <= S_NEXT;
					if (act_q == vsl_pkg::ACT_SCHED) begin
						if (!any_q || t_q < best_q) best_q <= t_q;
						any_q <= 1'b1;
					end else if (due) begin
						if (pend_v_q) st_q <= S_PUSH;
						else begin
							pend_v_q <= 1'b1;
							pend_s_q <= idx_q;
							pend_t_q <= t_q;
						end
					end
				end
				S_PUSH: if (out_free) begin
					ov_q     <= 1'b1;
					ol_q     <= 1'b0;
					od_q     <= {3'd0, 1'b0, 1'b1, pend_t_q, 4'(pend_s_q)};
					pend_s_q <= idx_q;
					pend_t_q <= t_q;
					st_q     <= S_NEXT;
				end
				S_NEXT: begin
					if (idx_q == vsl_pkg::SLOT_W'(vsl_pkg::SLOTS - 1)) st_q <= S_FIN;
					else begin
						idx_q <= idx_q + 1'b1;
						st_q  <= S_RD;
					end
				end
				S_FIN: if (out_free) begin
					ov_q <= 1'b1;
					ol_q <= 1'b1;
					if (act_q == vsl_pkg::ACT_SCHED)
						od_q <= {3'd0, 1'b0, any_q, best_q, 4'd0};
					else if (act_q == vsl_pkg::ACT_FIRE && pend_v_q)
						od_q <= {3'd0, 1'b0, 1'b1, pend_t_q, 4'(pend_s_q)};
					else
						od_q <= {3'd0, stat_q, 1'b0, 63'd0, 4'd0};
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_DIV) |-> (rem_q < pe))
		else $error("remainder out of range");
	a_pend_fire: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_v_q && st_q != S_IDLE) |-> (act_q == vsl_pkg::ACT_FIRE))
		else $error("pending result outside fire");
	a_delay_max: assert property (@(posedge clk) disable iff (!arst_n)
		delay_q <= 32'sd1500000)
		else $error("wakeup delay above clamp");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (st_q != S_IDLE))
		else $error("accepted item not taken up");

endmodule

FILE: verif/tb_vsync_listener_scheduler_core.sv
// Testbench for vsync_listener_scheduler_core: directed and random items with
// a built-in predictor of the slot table, wakeup delay and register settings.
// Depends on vsl_pkg and the core; needs no other files.
`timescale 1ns / 100ps

module tb_vsync_listener_scheduler_core;

	localparam longint TMAX63 = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam longint TMIN63 = -TMAX63 - 1;
	localparam longint WINDOW = 500000;
	localparam longint DLY_HI = 1500000;
	localparam longint DLY_LO = -64'sd2147483648;
	localparam int IDLE_LIMIT = 20000;
	localparam logic [2:0] ACT_SPARE = 3'd5;

	typedef struct {
		logic [3:0]  slot;
		logic [62:0] t;
		bit          has;
		bit          st;
		bit          last;
	} vs_result_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [159:0] s_axis_tdata;
	logic [2:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [71:0]  m_axis_tdata;
	logic         m_axis_tlast;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [61:0]  cfg_data;

	vs_result_t due_q[$];
	int         errors;
	int         burst_left;
	int         hold_cnt;
	bit         hold_req;
	int         stall_mode;
	int         mode_cnt;
	int         idle_cnt;
	longint     now_base;

	logic [29:0] p_period;
	longint      p_gphase;
	longint      p_reft;
	bit          p_ltps;
	bit          p_valid[vsl_pkg::SLOTS];
	longint      p_phase[vsl_pkg::SLOTS];
	longint      p_last[vsl_pkg::SLOTS];
	longint      p_delay;

	vsync_listener_scheduler_core dut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic longint sat63(longint x);
		if (x > TMAX63) return TMAX63;
		if (x < TMIN63) return TMIN63;
		return x;
	endfunction

	function automatic longint eff_period();
		return (p_period == 0) ? 64'sd1 : longint'({34'd0, p_period});
	endfunction

	function automatic longint slot_next(int s, longint now);
		longint p, lv, n, ph, t;
		p  = eff_period();
		lv = sat63(p_last[s] + p_delay);
		n  = (now < lv) ? lv : now;
		ph = p_gphase + p_phase[s];
		n  = sat63(n - p_reft);
		n  = sat63(n - ph);
		if (n < 0) n = -p;
		t = sat63((n / p + 1) * p + ph);
		t = sat63(t + p_reft);
		if (p_ltps && sat63(t - p_last[s]) < (3 * p) / 5) t = sat63(t + p);
		return sat63(t - p_delay);
	endfunction

	function automatic void push_result(int slot, longint t, bit has, bit st, bit last);
		vs_result_t r;
		r.slot = slot[3:0];
		r.t    = t[62:0];
		r.has  = has;
		r.st   = st;
		r.last = last;
		due_q = {due_q, r};
	endfunction

	function automatic void predict_item(logic [2:0] act, logic [3:0] id,
			logic [30:0] ph_raw, logic [61:0] now_raw, logic [61:0] tgt_raw, bit woke);
		longint ph, now, tgt, best, t, d, nts;
		bit any;
		int k;
		ph  = longint'($signed(ph_raw));
		now = longint'({2'b00, now_raw});
		tgt = longint'({2'b00, tgt_raw});
		any = 0;
		best = 0;
		k = 0;
		case (act) inside
			vsl_pkg::ACT_SCHED: begin
				for (int i = 0; i < vsl_pkg::SLOTS; i++) begin
					if (p_valid[i]) begin
						t = slot_next(i, now);
						if (!any || t < best) best = t;
						any = 1;
					end
				end
				push_result(0, best, any, 0, 1);
			end
			vsl_pkg::ACT_FIRE: begin
				if (woke) begin
					d = (p_delay * 63 + (now - tgt)) / 64;
					if (d > DLY_HI) d = DLY_HI;
					if (d < DLY_LO) d = DLY_LO;
					p_delay = d;
				end
				nts = p_ltps ? now - eff_period() : now;
				for (int i = 0; i < vsl_pkg::SLOTS; i++) begin
					if (p_valid[i]) begin
						t = slot_next(i, nts);
						if (t - now < WINDOW) begin
							p_last[i] = t;
							push_result(i, t, 1, 0, 0);
							k++;
						end
					end
				end
				if (k == 0) push_result(0, 0, 0, 0, 1);
				else due_q[$].last = 1;
			end
			vsl_pkg::ACT_ADD: begin
				p_valid[id] = 1;
				p_phase[id] = ph;
				p_last[id]  = sat63(now - eff_period() / 2 + p_gphase);
				push_result(0, 0, 0, 0, 1);
			end
			vsl_pkg::ACT_REMOVE, vsl_pkg::ACT_PHASE: begin
				if (!p_valid[id]) begin
					push_result(0, 0, 0, 1, 1);
				end else begin
					if (act == vsl_pkg::ACT_REMOVE) p_valid[id] = 0;
					else p_phase[id] = ph;
					push_result(0, 0, 0, 0, 1);
				end
			end
			default: push_result(0, 0, 0, 0, 1);
		endcase
	endfunction

	task automatic send_item(logic [2:0] act, logic [3:0] id, logic [30:0] ph,
			logic [61:0] now, logic [61:0] tgt, bit woke);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
			burst_left = $urandom_range(1, 10);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {woke, tgt, now, ph, id};
		do @(posedge clk); while (!s_axis_tready);
		predict_item(act, id, ph, now, tgt, woke);
		burst_left--;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (due_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [61:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			vsl_pkg::REG_PERIOD: p_period = val[29:0];
			vsl_pkg::REG_GPHASE: p_gphase = longint'($signed(val[30:0]));
			vsl_pkg::REG_REFT:   p_reft = longint'({2'b00, val});
			default:             p_ltps = val[0];
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(logic [29:0] per, longint gph, logic [61:0] reft, bit ltps);
		drain();
		write_reg(vsl_pkg::REG_PERIOD, {32'd0, per});
		write_reg(vsl_pkg::REG_GPHASE, 62'(gph[30:0]));
		write_reg(vsl_pkg::REG_REFT, reft);
		write_reg(vsl_pkg::REG_LTPS, {61'd0, ltps});
	endtask

	function automatic logic [61:0] rand62();
		return {$urandom(), $urandom()};
	endfunction

	task automatic send_random();
		int sel;
		logic [2:0] act;
		logic [30:0] ph;
		logic [61:0] now, tgt;
		longint span;
		sel  = $urandom_range(0, 99);
		span = (p_period == 0) ? 64'sd1 : longint'({34'd0, p_period});
		if (sel < 35) act = vsl_pkg::ACT_FIRE;
		else if (sel < 55) act = vsl_pkg::ACT_SCHED;
		else if (sel < 75) act = vsl_pkg::ACT_ADD;
		else if (sel < 85) act = vsl_pkg::ACT_REMOVE;
		else if (sel < 97) act = vsl_pkg::ACT_PHASE;
		else act = 3'($urandom_range(ACT_SPARE, 7));
		now_base += longint'($urandom_range(0, 1000000)) % (2 * span + 1);
		if ($urandom_range(0, 19) == 0) now = rand62();
		else now = now_base[61:0];
		if ($urandom_range(0, 9) == 0) ph = 31'($urandom());
		else ph = 31'(longint'($urandom_range(0, 2000000)) - 1000000);
		if ($urandom_range(0, 9) == 0) tgt = rand62();
		else tgt = now - 62'($urandom_range(0, 3000000));
		send_item(act, 4'($urandom_range(0, 15)), ph, now, tgt, 1'($urandom_range(0, 1)));
	endtask

	task automatic test_empty_table();
		send_item(vsl_pkg::ACT_SCHED, 0, 0, 0, 0, 0);
		send_item(vsl_pkg::ACT_FIRE, 0, 0, 62'd1000, 62'd0, 1);
		send_item(vsl_pkg::ACT_REMOVE, 4'd3, 0, 0, 0, 0);
		send_item(vsl_pkg::ACT_PHASE, 4'd15, 31'h7FFF_FFFF, 0, 0, 0);
		for (int a = ACT_SPARE; a < 8; a++)
			send_item(3'(a), 4'(a), 31'h5555_5555, 62'h2AAA_AAAA_AAAA_AAAA,
				62'h1555_5555_5555_5555, 1);
	endtask

	task automatic test_extremes();
		send_item(vsl_pkg::ACT_ADD, 4'd0, 31'h4000_0000, 62'd0, 62'd0, 0);
		send_item(vsl_pkg::ACT_ADD, 4'd15, 31'h3FFF_FFFF, 62'h3FFF_FFFF_FFFF_FFFF, 0, 0);
		send_item(vsl_pkg::ACT_SCHED, 0, 0, 62'd0, 0, 0);
		send_item(vsl_pkg::ACT_SCHED, 0, 0, 62'h3FFF_FFFF_FFFF_FFFF, 0, 0);
		send_item(vsl_pkg::ACT_FIRE, 0, 0, 62'h3FFF_FFFF_FFFF_FFFF, 62'd0, 1);
		send_item(vsl_pkg::ACT_FIRE, 0, 0, 62'd0, 62'h3FFF_FFFF_FFFF_FFFF, 1);
		send_item(vsl_pkg::ACT_PHASE, 4'd0, 31'd0, 0, 0, 0);
		send_item(vsl_pkg::ACT_ADD, 4'd0, 31'd250000, 62'd5000000, 0, 0);
		send_item(vsl_pkg::ACT_FIRE, 0, 0, 62'd5000000, 62'd4000000, 1);
		send_item(vsl_pkg::ACT_REMOVE, 4'd15, 0, 0, 0, 0);
		send_item(vsl_pkg::ACT_REMOVE, 4'd15, 0, 0, 0, 0);
		send_item(vsl_pkg::ACT_SCHED, 0, 0, 62'd6000000, 0, 0);
		send_item(vsl_pkg::ACT_REMOVE, 4'd0, 0, 0, 0, 0);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) send_random();
	endtask

	task automatic test_backpressure();
		drain();
		hold_req = 1;
		test_random(30);
	endtask

	initial begin
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		burst_left = 0;
		hold_req = 0;
		now_base = 64'sd1000000000000;
		p_period = vsl_pkg::PERIOD_RST;
		p_gphase = 0;
		p_reft = 0;
		p_ltps = 0;
		p_delay = 0;
		for (int i = 0; i < vsl_pkg::SLOTS; i++) begin
			p_valid[i] = 0;
			p_phase[i] = 0;
			p_last[i] = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_empty_table();
		test_extremes();
		set_config(30'd1000000, 0, 62'd0, 0);
		test_random(50);
		set_config(30'd1000000, 123456, 62'd777777, 1);
		test_random(40);
		set_config(30'd1, -64'sd1000000000, 62'h3FFF_FFFF_FFFF_FFFF, 0);
		test_random(25);
		set_config(30'd1000000000, 64'sd1000000000, 62'd0, 1);
		test_random(25);
		set_config(30'd0, -64'sd1073741824, 62'h2AAA_AAAA_AAAA_AAAA, 1);
		test_random(20);
		set_config(30'd3000000, 64'sd1073741823, 62'h1555_5555_5555_5555, 0);
		test_random(40);
		test_backpressure();
		drain();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		m_axis_tready = 0;
		hold_cnt = 0;
		stall_mode = 0;
		mode_cnt = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				hold_cnt = 3000;
			end
			if (mode_cnt == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_cnt = $urandom_range(20, 200);
			end else begin
				mode_cnt--;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_axis_tready <= 1'b0;
			end else if (stall_mode == 0) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	always @(posedge clk) begin
		vs_result_t r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (due_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h last %b",
					$realtime, m_axis_tdata, m_axis_tlast);
			end else begin
				r = due_q.pop_front();
				if (m_axis_tdata[3:0] !== r.slot) begin
					errors++;
					$display("%0t: slot expected %0d actual %0d", $realtime, r.slot,
						m_axis_tdata[3:0]);
				end
				if (m_axis_tdata[66:4] !== r.t) begin
					errors++;
					$display("%0t: event_time expected %h actual %h", $realtime, r.t,
						m_axis_tdata[66:4]);
				end
				if (m_axis_tdata[67] !== r.has) begin
					errors++;
					$display("%0t: has_time expected %b actual %b", $realtime, r.has,
						m_axis_tdata[67]);
				end
				if (m_axis_tdata[68] !== r.st) begin
					errors++;
					$display("%0t: status expected %b actual %b", $realtime, r.st,
						m_axis_tdata[68]);
				end
				if (m_axis_tlast !== r.last) begin
					errors++;
					$display("%0t: last expected %b actual %b", $realtime, r.last,
						m_axis_tlast);
				end
			end
		end
	end

	initial begin
		idle_cnt = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready) || !s_axis_tvalid && due_q.size() == 0)
				idle_cnt = 0;
			else
				idle_cnt++;
			if (idle_cnt >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

endmodule
